// ----- design/amms_pkg.sv -----
// Shared types and constants for the array min/max/mode/sort block.
// Holds the controller states, the command and status structs and the field widths.
// No dependencies.
`default_nettype none

package amms_pkg;

  // Fixed field widths.
  localparam int VALUE_W     = 32;
  localparam int MODE_CNT_W  = 6;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 136;

  // Controller states.
  typedef enum logic [1:0] {
    ST_COLLECT = 2'd0,
    ST_SCAN    = 2'd1,
    ST_SUMMARY = 2'd2,
    ST_EMIT    = 2'd3
  } amms_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // Take the input item into the lanes.
    logic ptr_clr;      // Reset the walk pointer; together with load, also clear the best-count register.
    logic ptr_inc;      // Advance the walk pointer.
    logic scan_en;      // Compare the pointed count against the best so far.
    logic sel_summary;  // Present the summary fields on the output data.
    logic clear_set;    // Return the set state to its reset values.
  } amms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;       // The walk pointer sits on the last stored element.
  } amms_stat_t;

endpackage

`default_nettype wire

// ----- design/amms_ctrl.sv -----
// Controller state machine for the array min/max/mode/sort block.
// Drives the handshakes and issues commands to amms_dpath; depends on amms_pkg.
`default_nettype none

module amms_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tlast,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic                    out_tlast,
  output logic                    out_tuser,
  output amms_pkg::amms_cmd_t     cmd,
  input  wire amms_pkg::amms_stat_t stat
);

  amms_pkg::amms_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= amms_pkg::ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    out_tlast   = 1'b0;
    out_tuser   = 1'b0;
    case (state_r)
      amms_pkg::ST_COLLECT: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            cmd.ptr_clr = 1'b1;
            state_nxt   = amms_pkg::ST_SCAN;
          end
        end
      end
      amms_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.at_end) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = amms_pkg::ST_SUMMARY;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      amms_pkg::ST_SUMMARY: begin
        out_tvalid      = 1'b1;
        out_tuser       = 1'b1;
        cmd.sel_summary = 1'b1;
        if (out_tready) begin
          state_nxt = amms_pkg::ST_EMIT;
        end
      end
      amms_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        out_tlast  = stat.at_end;
        if (out_tready) begin
          if (stat.at_end) begin
            cmd.clear_set = 1'b1;
            state_nxt     = amms_pkg::ST_COLLECT;
          end else begin
            cmd.ptr_inc = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = amms_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/amms_dpath.sv -----
// Datapath for the array min/max/mode/sort block: element lanes with occurrence
// counters, an insertion sorter chain, running max/min and the mode scan.
// Depends on amms_pkg; driven by amms_ctrl.
`default_nettype none

module amms_dpath #(
  parameter int MAX_ITEMS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic signed [amms_pkg::VALUE_W-1:0]  in_value,
  input  wire amms_pkg::amms_cmd_t                  cmd,
  output amms_pkg::amms_stat_t                      stat,
  output logic [amms_pkg::OUT_DATA_W-1:0]           out_data
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  // Lanes in arrival order: value and the number of equal values from this lane on.
  logic signed [amms_pkg::VALUE_W-1:0] val_r [MAX_ITEMS];
  logic signed [amms_pkg::VALUE_W-1:0] val_nxt [MAX_ITEMS];
  logic [CNT_W-1:0]                    occ_r [MAX_ITEMS];
  logic [CNT_W-1:0]                    occ_nxt [MAX_ITEMS];
  // Sorter chain, ascending over the first count_r cells.
  logic signed [amms_pkg::VALUE_W-1:0] srt_r [MAX_ITEMS];
  logic signed [amms_pkg::VALUE_W-1:0] srt_nxt [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]                le_v;

  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic signed [amms_pkg::VALUE_W-1:0] max_r, max_nxt;
  logic signed [amms_pkg::VALUE_W-1:0] min_r, min_nxt;
  logic                                drop_r, drop_nxt;
  logic [CNT_W-1:0]                    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]                    best_cnt_r, best_cnt_nxt;
  logic signed [amms_pkg::VALUE_W-1:0] best_val_r, best_val_nxt;
  logic                                store_ok;

  assign store_ok = (count_r < CNT_W'(MAX_ITEMS));

  // Lane and sorter update for one incoming element.
  always_comb begin
    for (int k = 0; k < MAX_ITEMS; k++) begin
      le_v[k] = (CNT_W'(k) < count_r) && !(in_value < srt_r[k]);
    end
    for (int k = 0; k < MAX_ITEMS; k++) begin
      val_nxt[k] = val_r[k];
      occ_nxt[k] = occ_r[k];
      srt_nxt[k] = srt_r[k];
      if (cmd.load && store_ok) begin
        if (CNT_W'(k) == count_r) begin
          val_nxt[k] = in_value;
          occ_nxt[k] = CNT_W'(1);
        end else if ((CNT_W'(k) < count_r) && (val_r[k] == in_value)) begin
          occ_nxt[k] = occ_r[k] + CNT_W'(1);
        end
        if (!le_v[k]) begin
          if (k == 0) begin
            srt_nxt[k] = in_value;
          end else if (le_v[k-1]) begin
            srt_nxt[k] = in_value;
          end else begin
            srt_nxt[k] = srt_r[k-1];
          end
        end
      end
    end
  end

  // Set-level registers, walk pointer and mode scan.
  always_comb begin
    count_nxt    = count_r;
    max_nxt      = max_r;
    min_nxt      = min_r;
    drop_nxt     = drop_r;
    ptr_nxt      = ptr_r;
    best_cnt_nxt = best_cnt_r;
    best_val_nxt = best_val_r;
    if (cmd.load) begin
      if (store_ok) begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == '0) begin
          max_nxt = in_value;
          min_nxt = in_value;
        end else begin
          if (max_r < in_value) max_nxt = in_value;
          if (in_value < min_r) min_nxt = in_value;
        end
      end else begin
        drop_nxt = 1'b1;
      end
    end
    if (cmd.scan_en && (occ_r[ptr_r[IDX_W-1:0]] > best_cnt_r)) begin
      best_cnt_nxt = occ_r[ptr_r[IDX_W-1:0]];
      best_val_nxt = val_r[ptr_r[IDX_W-1:0]];
    end
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
    // The best count is cleared as the scan is entered.
    if (cmd.ptr_clr && cmd.load) begin
      best_cnt_nxt = '0;
    end
    if (cmd.clear_set) begin
      count_nxt = '0;
      max_nxt   = '0;
      min_nxt   = '0;
      drop_nxt  = 1'b0;
      ptr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      max_r      <= '0;
      min_r      <= '0;
      drop_r     <= 1'b0;
      ptr_r      <= '0;
      best_cnt_r <= '0;
    end else begin
      count_r    <= count_nxt;
      max_r      <= max_nxt;
      min_r      <= min_nxt;
      drop_r     <= drop_nxt;
      ptr_r      <= ptr_nxt;
      best_cnt_r <= best_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_val_r <= best_val_nxt;
    for (int k = 0; k < MAX_ITEMS; k++) begin
      val_r[k] <= val_nxt[k];
      occ_r[k] <= occ_nxt[k];
      srt_r[k] <= srt_nxt[k];
    end
  end

  assign stat.at_end = (ptr_r == (count_r - CNT_W'(1)));

  // Output data packing, lowest field first; unused fields read as zero.
  always_comb begin
    if (cmd.sel_summary) begin
      out_data = {1'b0, {amms_pkg::VALUE_W{1'b0}}, drop_r,
                  amms_pkg::MODE_CNT_W'(best_cnt_r), best_val_r, min_r, max_r};
    end else begin
      out_data = {1'b0, srt_r[ptr_r[IDX_W-1:0]], 1'b0, {amms_pkg::MODE_CNT_W{1'b0}},
                  {(3 * amms_pkg::VALUE_W){1'b0}}};
    end
  end

endmodule

`default_nettype wire

// ----- design/array_min_max_mode_sort.sv -----
// Top level of the array min/max/mode/sort block: controller plus datapath.
// Depends on amms_pkg, amms_ctrl and amms_dpath.
//
//  Channel   Direction  Payload
//  in_*      in         tdata[31:0] value, tlast last_item
//  out_*     out        tdata summary or sorted fields, tuser is_summary, tlast last
//
// Elements are taken one per cycle while a set is being collected. After the
// transfer that carries in_tlast, the mode scan walks the stored occurrence
// counters, one per stored element, then one summary transfer and one sorted
// transfer per stored element follow. Input is not accepted from the last item
// of a set until the final sorted transfer. Reset is synchronous and active low
// and leaves an empty set; out_tready low simply holds the current result.
`default_nettype none

module array_min_max_mode_sort #(
  parameter int MAX_ITEMS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata: [31:0] value
  input  wire logic [amms_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // tdata: [31:0] max_value, [63:32] min_value, [95:64] mode_value,
  //        [101:96] mode_count, [102] overflow, [134:103] sorted_value, [135] zero
  output logic [amms_pkg::OUT_DATA_W-1:0]          out_tdata,
  // tuser: [0] is_summary
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  amms_pkg::amms_cmd_t  cmd;
  amms_pkg::amms_stat_t stat;

  // The controller sequences collection, the mode scan and the two output phases.
  amms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

  // The datapath keeps the lanes, the sorter chain and the running statistics.
  amms_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_tdata[amms_pkg::VALUE_W-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_tdata)
  );

  // The input and output sides are never active in the same cycle.
  a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output active together");

  // A set's last item closes the input until its results have gone out.
  a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still open after last item");

  // The summary is always followed by a sorted element.
  a_sorted_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser) |=> (out_tvalid && !out_tuser))
    else $error("no sorted element after summary");

  // The final sorted transfer reopens the input.
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("input not reopened after final result");

endmodule

`default_nettype wire
